>>> design/wss_pkg.sv
// ----------------------------------------------------------------------------
// Windowed sample statistics package
// Beat payload types, field widths and default sizes shared by the block.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int CHAN_W       = 8;
  localparam int DATA_W       = 16;
  localparam int STAMP_W      = 32;
  localparam int CHAN_OUT_W   = 2;
  localparam int MEAN_W       = 20;
  localparam int FILL_W       = 4;
  localparam int FRAC_W       = 4;

  localparam int WINDOW_DEF   = 10;
  localparam int CHANNELS_DEF = 4;

  typedef struct packed {
    logic        [CHAN_W-1:0]  channel;
    logic signed [DATA_W-1:0]  sample;
    logic        [STAMP_W-1:0] stamp;
  } in_t;

  typedef struct packed {
    logic        [STAMP_W-1:0]    stamp_out;
    logic        [CHAN_OUT_W-1:0] channel_out;
    logic signed [DATA_W-1:0]     latest;
    logic signed [DATA_W-1:0]     window_min;
    logic signed [DATA_W-1:0]     window_max;
    logic signed [MEAN_W-1:0]     window_mean;
    logic        [FILL_W-1:0]     filled;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> design/wss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module wss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/wss_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wss_div #(
  parameter int DVD_W = 24,
  parameter int DSR_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DSR_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output wss_pkg::div_status_t status
);
  import wss_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DSR_W-1:0] dsr;
  logic [CW-1:0]    count;
  logic             busy;
  logic             done;
  logic [DSR_W:0]   shifted;
  logic [DSR_W+1:0] diff;
  logic             fits;

  assign shifted = {rem, quo[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign fits    = !diff[DSR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> design/wss_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accept input beats, drop unknown channels, hold the rest in a two-entry queue.
// ----------------------------------------------------------------------------
module wss_front #(
  parameter int CHANNELS = wss_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wss_pkg::in_t  in_data,
  output logic          q_valid,
  output wss_pkg::in_t  q_item,
  input  logic          q_pop
);
  import wss_pkg::*;

  in_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;
  logic       push;

  assign in_ready = (level != 2'd2);
  assign push     = in_valid && in_ready && (in_data.channel < CHAN_W'(CHANNELS));
  assign q_valid  = (level != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        level <= level + 2'd1;
      end else if (q_pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

>>> design/wss_back.sv
// ----------------------------------------------------------------------------
// Back end
// Store the sample, walk the channel window, divide, and hold the result beat.
// ----------------------------------------------------------------------------
module wss_back #(
  parameter int WINDOW   = wss_pkg::WINDOW_DEF,
  parameter int CHANNELS = wss_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  wss_pkg::in_t  q_item,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output wss_pkg::out_t out_data
);
  import wss_pkg::*;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int DVD_W = SUM_W + FRAC_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WRITE = 7'b0000010,
    S_READ  = 7'b0000100,
    S_LAST  = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                   state;
  in_t                      item;
  logic [CH_W-1:0]          ch;
  logic [AW-1:0]            base;
  logic [PTR_W-1:0]         wp_arr   [CHANNELS];
  logic [CNT_W-1:0]         fill_arr [CHANNELS];
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         rd_idx;
  logic                     acc_en;
  logic                     acc_first;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] mn;
  logic signed [DATA_W-1:0] mx;
  logic                     neg;

  logic [PTR_W-1:0]         wp_cur;
  logic [CNT_W-1:0]         fill_cur;
  logic [CNT_W-1:0]         fill_next;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] v;
  logic [SUM_W-1:0]         mag;
  logic                     div_start;
  logic [DVD_W-1:0]         quotient;
  div_status_t              div_st;
  logic [MEAN_W-1:0]        q_mean;
  logic signed [MEAN_W-1:0] mean;
  logic                     load_out;

  assign wp_cur    = wp_arr[ch];
  assign fill_cur  = fill_arr[ch];
  assign fill_next = (fill_cur == CNT_W'(WINDOW)) ? fill_cur : fill_cur + 1'b1;

  assign ram_we    = (state == S_WRITE);
  assign ram_addr  = (state == S_WRITE) ? base + AW'(wp_cur) : base + AW'(rd_idx);
  assign v         = $signed(ram_rdata);

  assign mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign div_start = (state == S_PREP);

  assign q_mean    = quotient[MEAN_W-1:0];
  assign mean      = neg ? $signed(-q_mean) : $signed(q_mean);

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  wss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item.sample),
    .rdata (ram_rdata)
  );

  wss_div #(
    .DVD_W (DVD_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, FRAC_W'(0)}),
    .divisor  (cnt),
    .quotient (quotient),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc_en    <= 1'b0;
      acc_first <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_arr[i]   <= '0;
        fill_arr[i] <= '0;
      end
    end else begin
      acc_en    <= (state == S_READ);
      acc_first <= (state == S_READ) && (rd_idx == '0);
      out_valid <= load_out || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          wp_arr[ch]   <= (wp_cur == PTR_W'(WINDOW - 1)) ? '0 : wp_cur + 1'b1;
          fill_arr[ch] <= fill_next;
          state        <= S_READ;
        end
        S_READ: begin
          if (rd_idx == cnt - 1'b1) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_PREP;
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
      ch   <= q_item.channel[CH_W-1:0];
      base <= AW'(q_item.channel[CH_W-1:0] * WINDOW);
    end
    if (state == S_WRITE) begin
      cnt    <= fill_next;
      rd_idx <= '0;
    end else if (state == S_READ) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (acc_en) begin
      if (acc_first) begin
        sum <= SUM_W'(v);
        mn  <= v;
        mx  <= v;
      end else begin
        sum <= sum + SUM_W'(v);
        if (v < mn) begin
          mn <= v;
        end
        if (v > mx) begin
          mx <= v;
        end
      end
    end
    if (div_start) begin
      neg <= sum[SUM_W-1];
    end
    if (load_out) begin
      out_data.stamp_out   <= item.stamp;
      out_data.channel_out <= item.channel[CHAN_OUT_W-1:0];
      out_data.latest      <= item.sample;
      out_data.window_min  <= mn;
      out_data.window_max  <= mx;
      out_data.window_mean <= mean;
      out_data.filled      <= FILL_W'(cnt);
    end
  end

endmodule

>>> design/windowed_sample_statistics_core.sv
// ----------------------------------------------------------------------------
// Windowed sample statistics core
// Per-channel sliding window of samples giving latest, min, max, mean, fill.
// ----------------------------------------------------------------------------
// Sequence: from queue head to result the item is popped and stored, the window
//   RAM is read once per filled entry, S_LAST and S_PREP drain the reads, the
//   bit-serial mean divider runs up to its done flag, and the result is loaded.
// Items are processed one at a time; the front queue takes two more meanwhile.
// Reset: clears pointers, fill counts, queue and result valid; window RAM
//   contents stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
module windowed_sample_statistics_core #(
  parameter int WINDOW   = wss_pkg::WINDOW_DEF,
  parameter int CHANNELS = wss_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wss_pkg::out_t out_data
);
  import wss_pkg::*;

  logic q_valid;
  in_t  q_item;
  logic q_pop;

  wss_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  wss_back #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_latest_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.window_min <= out_data.latest) &&
                  (out_data.latest <= out_data.window_max))
    else $error("latest sample outside window min and max");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.window_mean >= $signed({out_data.window_min, 4'b0000})) &&
                  (out_data.window_mean <= $signed({out_data.window_max, 4'b0000})))
    else $error("window mean outside window min and max");

endmodule
